/* rtl/wstd_pkg.sv */
`timescale 1ns / 1ps
package wstd_pkg;
  localparam int unsigned MaxWorkersDef = 4;
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned MaxTasksDef   = 64;

  localparam int unsigned KindW   = 3;
  localparam int unsigned WorkerW = 2;
  localparam int unsigned TaskW   = 6;
  localparam int unsigned StatusW = 3;
  localparam int unsigned SourceW = 2;
  localparam int unsigned CfgW    = 3;

  localparam logic [KindW-1:0] KindSubmit = 3'd0;
  localparam logic [KindW-1:0] KindWake   = 3'd1;
  localparam logic [KindW-1:0] KindYield  = 3'd2;
  localparam logic [KindW-1:0] KindFetch  = 3'd3;
  localparam logic [KindW-1:0] KindRetire = 3'd4;

  localparam logic [StatusW-1:0] StOk      = 3'd0;
  localparam logic [StatusW-1:0] StFull    = 3'd1;
  localparam logic [StatusW-1:0] StNoId    = 3'd2;
  localparam logic [StatusW-1:0] StUnknown = 3'd3;
  localparam logic [StatusW-1:0] StEmpty   = 3'd4;

  localparam logic [SourceW-1:0] SrcFast   = 2'd0;
  localparam logic [SourceW-1:0] SrcGlobal = 2'd1;
  localparam logic [SourceW-1:0] SrcLocal  = 2'd2;
  localparam logic [SourceW-1:0] SrcStolen = 2'd3;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [WorkerW-1:0] worker;
    logic               from_worker;
    logic [TaskW-1:0]   task_in;
  } req_t;

  typedef struct packed {
    logic [TaskW-1:0]   task_out;
    logic [StatusW-1:0] status;
    logic [SourceW-1:0] source;
  } rsp_t;
endpackage

/* rtl/wstd_req_if.sv */
`timescale 1ns / 1ps
interface wstd_req_if import wstd_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/wstd_rsp_if.sv */
`timescale 1ns / 1ps
interface wstd_rsp_if import wstd_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/work_stealing_task_dispatcher.sv */
`timescale 1ns / 1ps
// Flow: submit, wake, yield, retire and unused kinds go from DECODE straight to DONE; a
//   fetch from fast/global/local goes through QREAD, QWAIT, QMARK and DONE; a fetch that
//   scans victims probes each one through STEAL, SWAIT, SMARK, skipping ineligible ones.
// Only one item is in flight; the next is taken the cycle after the result leaves.
//   Queue, map and mark memories have registered reads.
// Reset: async active low; queues empty, ID counter and cursor zero, active_workers 1,
//   then S_CLEAR clears the live/started marks of all MAX_TASKS IDs before the first item.
module work_stealing_task_dispatcher import wstd_pkg::*; #(
  parameter int unsigned MAX_WORKERS = MaxWorkersDef,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned MAX_TASKS   = MaxTasksDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  wstd_req_if.sink        req,
  wstd_rsp_if.source      rsp
);
  localparam int unsigned WW   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned QPW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IDW  = $clog2(MAX_TASKS);
  localparam int unsigned FCW  = $clog2(MAX_TASKS + 1);
  // Queue numbering: fast 0..W-1, local W..2W-1, global 2W.
  localparam int unsigned NQ   = 2 * MAX_WORKERS + 1;
  localparam int unsigned QW   = $clog2(NQ);
  localparam int unsigned MW   = $clog2(NQ * QUEUE_DEPTH);
  localparam logic [QW-1:0] GlobalQ = QW'(2 * MAX_WORKERS);
  localparam int unsigned NW   = $clog2(MAX_WORKERS + 1);

  // Mark entry: bit 1 live, bit 0 started.
  localparam logic [1:0] MarkClear   = 2'b00;
  localparam logic [1:0] MarkLive    = 2'b10;
  localparam logic [1:0] MarkStarted = 2'b11;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_QREAD, S_QWAIT, S_QMARK, S_STEAL, S_SWAIT, S_SMARK,
    S_DONE
  } state_e;

  state_e state_q;
  req_t   req_q;
  rsp_t   rsp_q;
  logic   rsp_valid_q;
  logic [CfgW-1:0] act_q;

  // Queue pointers live in flops (small, indexed widely).
  logic [QPW-1:0]  head_q  [NQ];
  logic [CNTW-1:0] count_q [NQ];

  // Queue slots: one memory, single read/write port.
  logic [IDW-1:0] qmem [NQ * QUEUE_DEPTH];
  logic [IDW-1:0] qrd_q;
  logic [WW-1:0]  lwm [MAX_TASKS];
  logic [WW-1:0]  lwm_rd_q;
  logic [IDW-1:0] fstk [MAX_TASKS];
  logic [IDW-1:0] fstk_rd_q;
  logic [1:0]     mark_mem [MAX_TASKS];
  logic [1:0]     mark_rd_q;
  logic [FCW-1:0] free_cnt_q;
  logic [FCW-1:0] fresh_q;
  logic [WW-1:0]  rr_q;
  logic [IDW-1:0] clr_q;

  logic [QW-1:0]  q_sel_q;
  logic [WW-1:0]  off_q;
  logic           rich_q;

  // Effective worker count.
  logic [NW-1:0] n_w;
  always_comb begin
    if (act_q == '0) n_w = NW'(1);
    else if (32'(act_q) > MAX_WORKERS) n_w = NW'(MAX_WORKERS);
    else n_w = NW'(act_q);
  end

  logic [WW-1:0] rr_hint, rr_next;
  always_comb begin
    rr_hint = (32'(rr_q) < 32'(n_w)) ? rr_q : '0;
    rr_next = (32'(rr_hint) + 1 >= 32'(n_w)) ? '0 : WW'(32'(rr_hint) + 1);
  end

  function automatic logic [QW-1:0] fast_q(input logic [WW-1:0] w);
    return QW'(w);
  endfunction
  function automatic logic [QW-1:0] loc_q(input logic [WW-1:0] w);
    return QW'(32'(w) + MAX_WORKERS);
  endfunction

  logic [WW-1:0] req_w;
  assign req_w = WW'(req_q.worker);
  logic w_ok;
  assign w_ok = (32'(req_q.worker) < 32'(n_w));
  logic [IDW-1:0] tid;
  assign tid = IDW'(req_q.task_in);
  // Marks of task_in were read at the accept edge.
  logic t_ok;
  assign t_ok = (32'(req_q.task_in) < MAX_TASKS) && mark_rd_q[1];

  // Victim for steal probe.
  logic [WW-1:0] victim;
  always_comb begin
    logic [31:0] s;
    s = 32'(req_w) + 32'(off_q);
    victim = (s >= 32'(n_w)) ? WW'(s - 32'(n_w)) : WW'(s);
  end

  function automatic logic [MW-1:0] addr(input logic [QW-1:0] q, input logic [QPW-1:0] p);
    return MW'(32'(q) * QUEUE_DEPTH + 32'(p));
  endfunction
  // Slot index wrap; inputs stay below three times the depth.
  function automatic logic [QPW-1:0] wrap(input logic [31:0] v);
    logic [31:0] r;
    r = v;
    if (r >= 32'(2 * QUEUE_DEPTH)) r = r - 32'(2 * QUEUE_DEPTH);
    else if (r >= 32'(QUEUE_DEPTH)) r = r - 32'(QUEUE_DEPTH);
    return QPW'(r);
  endfunction

  logic           mem_we, mem_re;
  logic [MW-1:0]  mem_a;
  logic [IDW-1:0] mem_wd;

  // Side memories are read at the accept edge so DECODE sees the new item.
  logic [IDW-1:0] lwm_ra;
  logic [IDW-1:0] mk_ra;
  always_comb begin
    lwm_ra = (state_q == S_IDLE) ? IDW'(req.payload.task_in) : tid;
    if (state_q == S_IDLE) mk_ra = IDW'(req.payload.task_in);
    else if (state_q == S_QWAIT || state_q == S_SWAIT) mk_ra = qrd_q;
    else mk_ra = tid;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) qmem[mem_a] <= mem_wd;
    if (mem_re) qrd_q <= qmem[mem_a];
    lwm_rd_q  <= lwm[lwm_ra];
    fstk_rd_q <= fstk[IDW'(free_cnt_q - FCW'(1))];
  end

  logic           lwm_we;
  logic [IDW-1:0] lwm_a;
  logic [WW-1:0]  lwm_wd;
  logic           fs_we;
  logic           mk_we;
  logic [IDW-1:0] mk_wa;
  logic [1:0]     mk_wd;
  always_ff @(posedge clk_i) begin
    if (lwm_we) lwm[lwm_a] <= lwm_wd;
    if (fs_we) fstk[IDW'(free_cnt_q)] <= tid;
    if (mk_we) mark_mem[mk_wa] <= mk_wd;
    mark_rd_q <= mark_mem[mk_ra];
  end

  // Memory controls are combinational off the state register.
  logic [IDW-1:0] new_id;
  assign new_id = (free_cnt_q != '0) ? fstk_rd_q : IDW'(fresh_q);
  logic id_avail;
  assign id_avail = (free_cnt_q != '0) || (32'(fresh_q) < MAX_TASKS);

  // Push target for submit / wake / yield decided in DECODE.
  logic [QW-1:0] push_q;
  logic [WW-1:0] push_t;
  logic          push_ok;
  logic [IDW-1:0] push_id;
  always_comb begin
    logic [WW-1:0] t;
    push_q = GlobalQ; push_t = rr_hint; push_ok = 1'b0; push_id = tid;
    t = (req_q.kind == KindWake) ? lwm_rd_q : req_w;
    if (req_q.kind == KindSubmit) begin
      push_id = new_id;
      if (req_q.from_worker && w_ok) begin
        push_q = loc_q(req_w); push_t = req_w;
      end
      push_ok = id_avail && (32'(count_q[push_q]) < QUEUE_DEPTH);
    end else begin
      if (32'(t) >= 32'(n_w)) t = rr_hint;
      push_t = t;
      push_q = (req_q.kind == KindWake) ? fast_q(t) : loc_q(t);
      push_ok = t_ok && (32'(count_q[push_q]) < QUEUE_DEPTH);
    end
  end

  logic is_push;
  assign is_push = (req_q.kind == KindSubmit) || (req_q.kind == KindWake) ||
                   (req_q.kind == KindYield);

  // Fetch selection (queue order fast, global, local).
  logic [QW-1:0] fsel;
  logic          fhit;
  logic [SourceW-1:0] fsrc;
  always_comb begin
    fhit = w_ok; fsel = fast_q(req_w); fsrc = SrcFast;
    if (count_q[fast_q(req_w)] != '0) begin
      fsel = fast_q(req_w); fsrc = SrcFast;
    end else if (count_q[GlobalQ] != '0) begin
      fsel = GlobalQ; fsrc = SrcGlobal;
    end else if (count_q[loc_q(req_w)] != '0) begin
      fsel = loc_q(req_w); fsrc = SrcLocal;
    end else begin
      fhit = 1'b0;
    end
  end

  // Result item as decided in DECODE; fetch fields are filled in later.
  rsp_t dec_rsp;
  always_comb begin
    dec_rsp = '0;
    if (req_q.kind == KindSubmit) begin
      if (!id_avail) dec_rsp.status = StNoId;
      else if (!push_ok) dec_rsp.status = StFull;
      else dec_rsp.task_out = TaskW'(new_id);
    end else if (req_q.kind == KindWake || req_q.kind == KindYield) begin
      if (!t_ok) dec_rsp.status = StUnknown;
      else if (!push_ok) dec_rsp.status = StFull;
    end else if (req_q.kind == KindRetire) begin
      if (!t_ok) dec_rsp.status = StUnknown;
    end else if (req_q.kind == KindFetch) begin
      if (!w_ok) dec_rsp.status = StEmpty;
      else if (fhit) dec_rsp.source = fsrc;
    end
  end

  logic [QW-1:0] vq;
  assign vq = loc_q(victim);
  logic v_elig;
  assign v_elig = (32'(off_q) < 32'(n_w)) && (count_q[vq] != '0) &&
                  (!rich_q || 32'(count_q[vq]) > 1);

  always_comb begin
    mem_we = 1'b0; mem_re = 1'b0; mem_a = '0; mem_wd = push_id;
    lwm_we = 1'b0; lwm_a = tid; lwm_wd = push_t; fs_we = 1'b0;
    mk_we = 1'b0; mk_wa = tid; mk_wd = MarkClear;
    unique case (state_q)
      S_CLEAR: begin
        mk_we = 1'b1; mk_wa = clr_q;
      end
      S_DECODE: begin
        if (is_push && push_ok) begin
          mem_we = 1'b1;
          mem_a  = addr(push_q, wrap(32'(head_q[push_q]) + 32'(count_q[push_q])));
          lwm_we = 1'b1; lwm_a = push_id;
        end
        if (req_q.kind == KindSubmit && push_ok) begin
          mk_we = 1'b1; mk_wa = new_id; mk_wd = MarkLive;
        end
        if (req_q.kind == KindRetire && t_ok) begin
          mk_we = 1'b1; mk_wa = tid; mk_wd = MarkClear;
          if (32'(free_cnt_q) < MAX_TASKS) fs_we = 1'b1;
        end
      end
      S_QREAD: begin
        mem_re = 1'b1; mem_a = addr(fsel, head_q[fsel]);
      end
      S_QMARK: begin
        if (mark_rd_q[1]) begin
          mk_we = 1'b1; mk_wa = qrd_q; mk_wd = MarkStarted;
        end
      end
      S_STEAL: begin
        mem_re = 1'b1;
        mem_a  = addr(vq, wrap(32'(head_q[vq]) + 32'(count_q[vq]) + QUEUE_DEPTH - 1));
      end
      S_SMARK: begin
        if (!mark_rd_q[0] && mark_rd_q[1]) begin
          mk_we = 1'b1; mk_wa = qrd_q; mk_wd = MarkStarted;
        end
      end
      S_DONE: begin
        if (req_q.kind == KindFetch && rsp_q.status == StOk) begin
          lwm_we = 1'b1; lwm_a = rsp_q.task_out[IDW-1:0]; lwm_wd = req_w;
        end
      end
      default: ;
    endcase
  end

  assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp.valid   = rsp_valid_q;
  assign rsp.payload = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      rsp_valid_q <= 1'b0;
      act_q <= CfgW'(1);
      free_cnt_q <= '0; fresh_q <= '0; rr_q <= '0; clr_q <= '0;
      for (int i = 0; i < NQ; i++) begin head_q[i] <= '0; count_q[i] <= '0; end
      req_q <= '0; rsp_q <= '0; q_sel_q <= '0; off_q <= '0; rich_q <= 1'b0;
    end else begin
      if (cfg_we_i) act_q <= cfg_wdata_i;
      if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + IDW'(1);
          if (clr_q == IDW'(MAX_TASKS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            req_q <= req.payload;
            state_q <= S_DECODE;   // side reads (map, marks, free stack) settle here
          end
        end
        S_DECODE: begin
          rsp_q <= dec_rsp;
          priority case (1'b1)
            req_q.kind == KindSubmit: begin
              state_q <= S_DONE;
              if (push_ok) begin
                if (free_cnt_q != '0) free_cnt_q <= free_cnt_q - FCW'(1);
                else fresh_q <= fresh_q + FCW'(1);
                count_q[push_q] <= count_q[push_q] + CNTW'(1);
                if (push_q == GlobalQ) rr_q <= rr_next;
              end
            end
            req_q.kind == KindWake || req_q.kind == KindYield: begin
              state_q <= S_DONE;
              if (t_ok) begin
                if (32'((req_q.kind == KindWake) ? lwm_rd_q : req_w) >= 32'(n_w))
                  rr_q <= rr_next;
                if (push_ok) count_q[push_q] <= count_q[push_q] + CNTW'(1);
              end
            end
            req_q.kind == KindRetire: begin
              state_q <= S_DONE;
              if (t_ok && 32'(free_cnt_q) < MAX_TASKS) free_cnt_q <= free_cnt_q + FCW'(1);
            end
            req_q.kind == KindFetch: begin
              if (!w_ok) state_q <= S_DONE;
              else if (fhit) begin
                q_sel_q <= fsel; state_q <= S_QREAD;
              end else begin
                off_q <= WW'(1); rich_q <= 1'b1; state_q <= S_STEAL;
              end
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_QREAD: begin
          head_q[fsel] <= wrap(32'(head_q[fsel]) + 1);
          count_q[fsel] <= count_q[fsel] - CNTW'(1);
          state_q <= S_QWAIT;
        end
        S_QWAIT: begin
          // marks of the popped ID are read this cycle
          rsp_q.task_out <= TaskW'(qrd_q);
          state_q <= S_QMARK;
        end
        S_QMARK: begin
          if (!mark_rd_q[1]) rsp_q.status <= StUnknown;
          state_q <= S_DONE;
        end
        S_STEAL: begin
          if (32'(off_q) >= 32'(n_w) || off_q == '0) begin
            if (rich_q) begin
              rich_q <= 1'b0; off_q <= WW'(1);
            end else begin
              rsp_q.status <= StEmpty; state_q <= S_DONE;
            end
          end else if (v_elig) begin
            q_sel_q <= vq; state_q <= S_SWAIT;
          end else begin
            off_q <= off_q + WW'(1);
          end
        end
        S_SWAIT: begin
          state_q <= S_SMARK;
        end
        S_SMARK: begin
          if (mark_rd_q[0]) begin
            off_q <= off_q + WW'(1); state_q <= S_STEAL;
          end else begin
            count_q[q_sel_q] <= count_q[q_sel_q] - CNTW'(1);
            rsp_q.task_out <= TaskW'(qrd_q);
            rsp_q.source <= SrcStolen;
            if (!mark_rd_q[1]) rsp_q.status <= StUnknown;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          rsp_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Dispatcher testbench: drives request items through the req channel and
// keeps its own model of every queue, the ID pool and the marks. It checks
// each response item in order against the model.
module tb_top;
  import wstd_pkg::*;

  localparam logic [KindW-1:0] KindUnused = 3'd7;
  localparam int NumWorkers = 4;
  localparam int Depth      = 16;
  localparam int NumTasks   = 64;
  localparam int GlobalQ    = 2 * NumWorkers;  // queue index of the shared FIFO

  // Dispatch model plus in-order compare of response items.
  class dispatch_scoreboard;
    logic [TaskW-1:0]   slot[GlobalQ+1][Depth];
    int                 head[GlobalQ+1];
    int                 cnt[GlobalQ+1];
    logic [WorkerW-1:0] last_worker[NumTasks];
    bit                 started[NumTasks];
    bit                 live[NumTasks];
    logic [TaskW-1:0]   free_ids[NumTasks];
    int                 free_cnt;
    int                 fresh_id;
    int                 cursor;
    logic [CfgW-1:0]    workers_reg;
    rsp_t               exp_q[NumTasks];
    int                 exp_rd;
    int                 exp_wr;
    int                 in_flight;
    int                 errors;

    function new();
      for (int q = 0; q <= GlobalQ; q++) begin
        head[q] = 0;
        cnt[q]  = 0;
      end
      for (int t = 0; t < NumTasks; t++) begin
        started[t] = 0;
        live[t]    = 0;
      end
      free_cnt    = 0;
      fresh_id    = 0;
      cursor      = 0;
      workers_reg = 1;
      exp_rd      = 0;
      exp_wr      = 0;
      in_flight   = 0;
      errors      = 0;
    endfunction

    function int workers_used();
      if (workers_reg < 1) return 1;
      if (workers_reg > NumWorkers) return NumWorkers;
      return workers_reg;
    endfunction

    function int next_hint(int n);
      int h;
      h = (cursor < n) ? cursor : 0;
      cursor = (h + 1) % n;
      return h;
    endfunction

    function void push(int q, logic [TaskW-1:0] id);
      slot[q][(head[q] + cnt[q]) % Depth] = id;
      cnt[q]++;
    endfunction

    function logic [TaskW-1:0] take_front(int q);
      logic [TaskW-1:0] id;
      id = slot[q][head[q]];
      head[q] = (head[q] + 1) % Depth;
      cnt[q]--;
      return id;
    endfunction

    // Take from the back of a victim deque; rich pass skips single-entry deques.
    function bit steal(int thief, int n, bit rich, output logic [TaskW-1:0] id);
      int v;
      logic [TaskW-1:0] cand;
      id = '0;
      for (int off = 1; off < n; off++) begin
        v = NumWorkers + (thief + off) % n;
        if (cnt[v] == 0) continue;
        if (rich && cnt[v] <= 1) continue;
        cand = slot[v][(head[v] + cnt[v] - 1) % Depth];
        if (started[cand]) continue;
        cnt[v]--;
        id = cand;
        return 1;
      end
      return 0;
    endfunction

    function int pick_live();
      int k;
      k = $urandom_range(0, NumTasks - 1);
      for (int i = 0; i < NumTasks; i++) begin
        if (live[(k + i) % NumTasks]) return (k + i) % NumTasks;
      end
      return k;
    endfunction

    // Accepted request: work out the response item it must produce.
    function void note_request(req_t r);
      rsp_t e;
      int n, q, t;
      bit is_local, got;
      logic [TaskW-1:0] id;
      n = workers_used();
      e = '0;
      e.status = StOk;
      e.source = SrcFast;
      case (r.kind)
        KindSubmit: begin
          is_local = r.from_worker && (r.worker < n);
          q = is_local ? NumWorkers + r.worker : GlobalQ;
          if (free_cnt == 0 && fresh_id >= NumTasks) begin
            e.status = StNoId;
          end else if (cnt[q] >= Depth) begin
            e.status = StFull;
          end else begin
            if (free_cnt > 0) begin
              free_cnt--;
              id = free_ids[free_cnt];
            end else begin
              id = TaskW'(fresh_id);
              fresh_id++;
            end
            live[id] = 1;
            started[id] = 0;
            last_worker[id] = is_local ? r.worker : WorkerW'(next_hint(n));
            push(q, id);
            e.task_out = id;
          end
        end
        KindWake, KindYield, KindRetire: begin
          if (!live[r.task_in]) begin
            e.status = StUnknown;
          end else if (r.kind == KindRetire) begin
            live[r.task_in] = 0;
            started[r.task_in] = 0;
            if (free_cnt < NumTasks) begin
              free_ids[free_cnt] = r.task_in;
              free_cnt++;
            end
          end else begin
            t = (r.kind == KindWake) ? last_worker[r.task_in] : r.worker;
            if (t >= n) t = next_hint(n);
            q = (r.kind == KindWake) ? t : NumWorkers + t;
            if (cnt[q] >= Depth) begin
              e.status = StFull;
            end else begin
              last_worker[r.task_in] = WorkerW'(t);
              push(q, r.task_in);
            end
          end
        end
        KindFetch: begin
          got = 0;
          id = '0;
          if (r.worker < n) begin
            got = 1;
            if (cnt[r.worker] > 0) begin
              id = take_front(r.worker);
              e.source = SrcFast;
            end else if (cnt[GlobalQ] > 0) begin
              id = take_front(GlobalQ);
              e.source = SrcGlobal;
            end else if (cnt[NumWorkers + r.worker] > 0) begin
              id = take_front(NumWorkers + r.worker);
              e.source = SrcLocal;
            end else if (steal(r.worker, n, 1, id) || steal(r.worker, n, 0, id)) begin
              e.source = SrcStolen;
            end else begin
              got = 0;
            end
          end
          if (!got) begin
            e.status = StEmpty;
            e.source = SrcFast;
          end else begin
            e.task_out = id;
            // stale entry: retired while still queued
            if (!live[id]) begin
              e.status = StUnknown;
            end else begin
              started[id] = 1;
              last_worker[id] = r.worker;
            end
          end
        end
        default: ;
      endcase
      exp_q[exp_wr] = e;
      exp_wr = (exp_wr + 1) % NumTasks;
      in_flight++;
    endfunction

    function void check_response(rsp_t a);
      rsp_t e;
      if (in_flight == 0) begin
        $display("%0t: unexpected response item %p", $time, a);
        errors++;
        return;
      end
      e = exp_q[exp_rd];
      exp_rd = (exp_rd + 1) % NumTasks;
      in_flight--;
      if (a.task_out !== e.task_out) begin
        $display("%0t: task_out expected %0d actual %0d", $time, e.task_out, a.task_out);
        errors++;
      end
      if (a.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
        errors++;
      end
      if (a.source !== e.source) begin
        $display("%0t: source expected %0d actual %0d", $time, e.source, a.source);
        errors++;
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  wstd_req_if req ();
  wstd_rsp_if rsp ();

  work_stealing_task_dispatcher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req),
    .rsp        (rsp)
  );

  dispatch_scoreboard sb;
  bit quiet;       // no idling on either side in the closing stretch
  int retire_wt;   // per-phase retire weight; low values drain the ID pool

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Response side: accept in random stall bursts, check every item taken.
  int rsp_hold = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) sb.check_response(rsp.payload);
      if (rsp_hold > 0) begin
        rsp_hold <= rsp_hold - 1;
        rsp.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rsp_hold <= $urandom_range(0, 15);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  function req_t make_req(logic [KindW-1:0] k, int w, int f, int t);
    req_t r;
    r.kind = k;
    r.worker = WorkerW'(w);
    r.from_worker = 1'(f);
    r.task_in = TaskW'(t);
    return r;
  endfunction

  // Hold the item until accepted, then maybe drop valid for a burst.
  task automatic send(req_t r);
    int gap;
    req.valid <= 1'b1;
    req.payload <= r;
    do @(posedge clk_i); while (!req.ready);
    sb.note_request(r);
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Only touch the register once every response is back and the block is idle.
  task automatic write_workers(int v);
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.in_flight != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CfgW'(v);
    @(posedge clk_i);
    sb.workers_reg = CfgW'(v);
    cfg_we_i <= 1'b0;
  endtask

  function req_t random_req();
    int sel, t;
    logic [KindW-1:0] k;
    sel = $urandom_range(0, 99 + retire_wt);
    if (sel < 30) k = KindSubmit;
    else if (sel < 42) k = KindWake;
    else if (sel < 54) k = KindYield;
    else if (sel < 96) k = KindFetch;
    else if (sel < 100) k = KindW'($urandom_range(5, 7));
    else k = KindRetire;
    t = ($urandom_range(0, 3) != 0) ? sb.pick_live() : $urandom_range(0, NumTasks - 1);
    return make_req(k, $urandom_range(0, 3), $urandom_range(0, 1), t);
  endfunction

  int phase_vals[8] = '{4, 2, 0, 7, 3, 1, 5, 4};

  initial begin
    sb = new();
    quiet = 0;
    retire_wt = 12;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    req.valid <= 1'b0;
    req.payload <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: each kind, inactive worker, unknown task, empty fetch.
    send(make_req(KindFetch, 0, 0, 0));       // nothing to fetch
    send(make_req(KindSubmit, 0, 1, 0));      // local deque of worker 0
    send(make_req(KindSubmit, 3, 1, 63));     // inactive worker goes global
    send(make_req(KindSubmit, 2, 0, 0));      // global
    send(make_req(KindFetch, 3, 0, 0));       // inactive fetcher
    send(make_req(KindFetch, 0, 0, 0));       // global front
    send(make_req(KindWake, 0, 0, 0));
    send(make_req(KindYield, 3, 0, 1));       // inactive yield target
    send(make_req(KindRetire, 0, 0, 63));     // unknown task
    send(make_req(KindUnused, 3, 1, 63));
    send(make_req(3'd5, 0, 0, 0));
    send(make_req(3'd6, 0, 0, 0));
    send(make_req(KindFetch, 0, 0, 0));
    send(make_req(KindFetch, 0, 0, 0));
    send(make_req(KindFetch, 0, 0, 0));
    send(make_req(KindRetire, 0, 0, 2));
    send(make_req(KindFetch, 0, 0, 0));       // may pop a retired entry
    send(make_req(KindSubmit, 1, 0, 0));      // reuses a freed ID
    send(make_req(KindFetch, 0, 0, 0));

    // Random phases over several register settings.
    foreach (phase_vals[p]) begin
      write_workers(phase_vals[p]);
      case ($urandom_range(0, 2))
        0: retire_wt = 1;
        1: retire_wt = 12;
        default: retire_wt = 30;
      endcase
      if (p == 7) quiet = 1;
      repeat (225) send(random_req());
    end
    req.valid <= 1'b0;

    while (sb.in_flight != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
